FILE: sv/ccr_pkg.sv
// Shared types, widths and saturation helpers for the disc pair collision pipeline.
`timescale 1ns / 1ps

package ccr_pkg;

   localparam int POS_W      = 20;
   localparam int VEL_W      = 16;
   localparam int RAD_W      = 16;
   localparam int ELA_W      = 9;
   localparam int DIFF_W     = POS_W + 1;
   localparam int DX_W       = RAD_W + 2;
   localparam int RSUM_W     = RAD_W + 1;
   localparam int RVEL_W     = VEL_W + 1;
   localparam int F_W        = 11;
   localparam int F_ONE      = 512;
   localparam int F_SHIFT    = 9;
   localparam int SQ_W       = 2 * POS_W;
   localparam int D2_W       = SQ_W + 1;
   localparam int PV_W       = RVEL_W + DIFF_W;
   localparam int VDOT_W     = 36;
   localparam int SQ_IN_W    = 2 * RSUM_W;
   localparam int SQ_OUT_W   = RSUM_W;
   localparam int SQ_STEPS   = RSUM_W;
   localparam int PEN_W      = RSUM_W + 1;
   localparam int DIV_QW     = 19;
   localparam int DIV_NUM_W  = 54;
   localparam int DIV_DEN_W  = 2 * RSUM_W;
   localparam int PIPE_DEPTH = 48;
   localparam int CAPACITY   = PIPE_DEPTH + 2;

   localparam logic [POS_W-1:0]        POS_MAX = '1;
   localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
   localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};

   typedef struct packed {
      logic [POS_W-1:0]        a_pos_x;
      logic [POS_W-1:0]        a_pos_y;
      logic signed [VEL_W-1:0] a_vel_x;
      logic signed [VEL_W-1:0] a_vel_y;
      logic [RAD_W-1:0]        a_radius;
      logic [ELA_W-1:0]        a_elasticity;
      logic [POS_W-1:0]        b_pos_x;
      logic [POS_W-1:0]        b_pos_y;
      logic signed [VEL_W-1:0] b_vel_x;
      logic signed [VEL_W-1:0] b_vel_y;
      logic [RAD_W-1:0]        b_radius;
      logic [ELA_W-1:0]        b_elasticity;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]        new_a_pos_x;
      logic [POS_W-1:0]        new_a_pos_y;
      logic signed [VEL_W-1:0] new_a_vel_x;
      logic signed [VEL_W-1:0] new_a_vel_y;
      logic [POS_W-1:0]        new_b_pos_x;
      logic [POS_W-1:0]        new_b_pos_y;
      logic signed [VEL_W-1:0] new_b_vel_x;
      logic signed [VEL_W-1:0] new_b_vel_y;
      logic                    overlapping;
      logic                    coincident;
   } rsp_type;

   typedef struct packed {
      req_type                  pl;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic [RSUM_W-1:0]        rsum;
      logic signed [RVEL_W-1:0] rvx;
      logic signed [RVEL_W-1:0] rvy;
      logic [F_W-1:0]           f;
      logic                     overlap;
      logic                     coinc;
      logic                     active;
      logic                     vneg;
      logic [SQ_IN_W-1:0]       d2m;
      logic signed [VDOT_W-1:0] vdot;
   } ctx_type;

   function automatic logic [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
      logic [POS_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed((POS_W+2)'(POS_MAX))) begin
         r = POS_MAX;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VEL_W+4:0] v);
      logic signed [VEL_W-1:0] r;
      if (v < (VEL_W+5)'(VEL_MIN)) begin
         r = VEL_MIN;
      end else if (v > (VEL_W+5)'(VEL_MAX)) begin
         r = VEL_MAX;
      end else begin
         r = v[VEL_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: sv/ccr_if.sv
// Valid/ready channel interfaces for the request and response transactions.
`timescale 1ns / 1ps

interface ccr_req_if import ccr_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ccr_rsp_if import ccr_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/circle_pair_collision_resolve.sv
// Top level: disc pair overlap test, impulse and penetration correction pipeline.
//
//   channel  direction  handshake     transaction
//   req_ch   in         valid/ready   one disc pair (req_type)
//   rsp_ch   out        valid/ready   updated pair and flags (rsp_type)
//
// One pair enters per cycle while req_ch.ready is high.
// The pipeline holds the square root (17 stages) and two divider passes of 20 stages.
// The whole pipeline advances together; a one-entry skid behind the output register
// absorbs a stalled response, and req_ch.ready drops while that skid is full or reset is high.
// Reset is synchronous and clears the valid bits; no clearing pass is needed.
`timescale 1ns / 1ps

module circle_pair_collision_resolve import ccr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   ccr_req_if.sink   req_ch,
   ccr_rsp_if.source rsp_ch
);

   logic                    en;
   logic                    acc;
   logic                    take;
   logic                    push;
   logic [PIPE_DEPTH:1]     v_ff;
   ctx_type                 ctx_ff [1:PIPE_DEPTH-1];
   ctx_type                 ctx1_in;
   ctx_type                 ctx2_in;
   ctx_type                 ctx4_in;

   logic signed [2*DIFF_W-1:0]        dxx_p, dyy_p;
   logic [SQ_W-1:0]                   dxx_ff, dyy_ff;
   logic [SQ_IN_W-1:0]                rs2_ff;
   logic signed [PV_W-1:0]            pvx_ff, pvy_ff;
   logic [D2_W-1:0]                   d2;
   logic signed [PV_W:0]              vdot_full;

   logic signed [VDOT_W+DX_W-1:0]     nx_ff, ny_ff;
   logic signed [DIV_QW:0]            px_q, py_q;
   logic signed [DIV_QW+F_W+1:0]      pfx_ff, pfy_ff;
   logic signed [DIV_QW+F_W+RAD_W+2:0] mbx_ff, mby_ff, max_ff, may_ff;

   logic [SQ_OUT_W-1:0]               norm;
   logic signed [PEN_W-1:0]           pen_ff;
   logic [DIV_DEN_W-1:0]              denp_ff, denp2_ff, denp3_ff;
   logic signed [DX_W+PEN_W-1:0]      sx_ff, sy_ff;
   logic signed [DX_W+PEN_W+RAD_W:0]  shbx_ff, shby_ff, shax_ff, shay_ff;
   logic [DIV_DEN_W-1:0]              denv;

   logic signed [DIV_QW:0]            dvbx_q, dvby_q, dvax_q, dvay_q;
   logic signed [DIV_QW:0]            shbx_q, shby_q, shax_q, shay_q;

   rsp_type                           res_in, res_ff, out_ff, skid_ff;
   logic                              out_v_ff, skid_v_ff;
   ctx_type                           cl;
   logic                              vel_on;

   assign en           = !skid_v_ff;
   assign req_ch.ready = en && !reset;
   assign acc          = req_ch.valid && req_ch.ready;
   assign take         = out_v_ff && rsp_ch.ready;
   assign push         = en && v_ff[PIPE_DEPTH];
   assign rsp_ch.valid   = out_v_ff;
   assign rsp_ch.payload = out_ff;

   always_comb begin
      ctx1_in    = '0;
      ctx1_in.pl = req_ch.payload;
   end

   always_comb begin
      ctx2_in      = ctx_ff[1];
      ctx2_in.dx   = $signed({1'b0, ctx_ff[1].pl.b_pos_x}) - $signed({1'b0, ctx_ff[1].pl.a_pos_x});
      ctx2_in.dy   = $signed({1'b0, ctx_ff[1].pl.b_pos_y}) - $signed({1'b0, ctx_ff[1].pl.a_pos_y});
      ctx2_in.rsum = RSUM_W'(ctx_ff[1].pl.a_radius) + RSUM_W'(ctx_ff[1].pl.b_radius);
      ctx2_in.rvx  = RVEL_W'(ctx_ff[1].pl.b_vel_x) - RVEL_W'(ctx_ff[1].pl.a_vel_x);
      ctx2_in.rvy  = RVEL_W'(ctx_ff[1].pl.b_vel_y) - RVEL_W'(ctx_ff[1].pl.a_vel_y);
      ctx2_in.f    = F_W'(F_ONE) + F_W'(ctx_ff[1].pl.a_elasticity)
                   + F_W'(ctx_ff[1].pl.b_elasticity);
   end

   assign dxx_p = ctx_ff[2].dx * ctx_ff[2].dx;
   assign dyy_p = ctx_ff[2].dy * ctx_ff[2].dy;

   assign d2        = {1'b0, dxx_ff} + {1'b0, dyy_ff};
   assign vdot_full = (PV_W+1)'(pvx_ff) + (PV_W+1)'(pvy_ff);

   always_comb begin
      ctx4_in         = ctx_ff[3];
      ctx4_in.overlap = d2 < D2_W'(rs2_ff);
      ctx4_in.coinc   = (ctx_ff[3].dx == '0) && (ctx_ff[3].dy == '0);
      ctx4_in.active  = ctx4_in.overlap && !ctx4_in.coinc;
      ctx4_in.vneg    = vdot_full < 0;
      ctx4_in.d2m     = ctx4_in.active ? d2[SQ_IN_W-1:0] : '0;
      ctx4_in.vdot    = ctx4_in.active ? vdot_full[VDOT_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_ff[1] <= ctx1_in;
         ctx_ff[2] <= ctx2_in;
         ctx_ff[3] <= ctx_ff[2];
         ctx_ff[4] <= ctx4_in;
         for (int k = 5; k < PIPE_DEPTH; k++) begin
            ctx_ff[k] <= ctx_ff[k-1];
         end
         dxx_ff <= dxx_p[SQ_W-1:0];
         dyy_ff <= dyy_p[SQ_W-1:0];
         rs2_ff <= ctx_ff[2].rsum * ctx_ff[2].rsum;
         pvx_ff <= ctx_ff[2].rvx * ctx_ff[2].dx;
         pvy_ff <= ctx_ff[2].rvy * ctx_ff[2].dy;
         nx_ff  <= ctx_ff[4].vdot * $signed(ctx_ff[4].dx[DX_W-1:0]);
         ny_ff  <= ctx_ff[4].vdot * $signed(ctx_ff[4].dy[DX_W-1:0]);
         pfx_ff <= px_q * $signed({1'b0, ctx_ff[25].f});
         pfy_ff <= py_q * $signed({1'b0, ctx_ff[25].f});
         mbx_ff <= pfx_ff * $signed({1'b0, ctx_ff[26].pl.a_radius});
         mby_ff <= pfy_ff * $signed({1'b0, ctx_ff[26].pl.a_radius});
         max_ff <= pfx_ff * $signed({1'b0, ctx_ff[26].pl.b_radius});
         may_ff <= pfy_ff * $signed({1'b0, ctx_ff[26].pl.b_radius});
         pen_ff   <= $signed({1'b0, ctx_ff[24].rsum}) - $signed({1'b0, norm});
         denp_ff  <= ctx_ff[24].rsum * norm;
         sx_ff    <= $signed(ctx_ff[25].dx[DX_W-1:0]) * pen_ff;
         sy_ff    <= $signed(ctx_ff[25].dy[DX_W-1:0]) * pen_ff;
         denp2_ff <= denp_ff;
         shbx_ff  <= sx_ff * $signed({1'b0, ctx_ff[26].pl.a_radius});
         shby_ff  <= sy_ff * $signed({1'b0, ctx_ff[26].pl.a_radius});
         shax_ff  <= sx_ff * $signed({1'b0, ctx_ff[26].pl.b_radius});
         shay_ff  <= sy_ff * $signed({1'b0, ctx_ff[26].pl.b_radius});
         denp3_ff <= denp2_ff;
         res_ff   <= res_in;
      end
   end

   ccr_div u_div_px (.clock(clock), .en(en), .num(DIV_NUM_W'(nx_ff)), .den(ctx_ff[5].d2m),
                     .quo(px_q));
   ccr_div u_div_py (.clock(clock), .en(en), .num(DIV_NUM_W'(ny_ff)), .den(ctx_ff[5].d2m),
                     .quo(py_q));

   ccr_sqrt u_sqrt (.clock(clock), .en(en), .rad(ctx_ff[7].d2m), .root(norm));

   assign denv = DIV_DEN_W'(ctx_ff[27].rsum) << F_SHIFT;

   ccr_div u_div_dvbx (.clock(clock), .en(en), .num(DIV_NUM_W'(mbx_ff)), .den(denv),
                       .quo(dvbx_q));
   ccr_div u_div_dvby (.clock(clock), .en(en), .num(DIV_NUM_W'(mby_ff)), .den(denv),
                       .quo(dvby_q));
   ccr_div u_div_dvax (.clock(clock), .en(en), .num(DIV_NUM_W'(max_ff)), .den(denv),
                       .quo(dvax_q));
   ccr_div u_div_dvay (.clock(clock), .en(en), .num(DIV_NUM_W'(may_ff)), .den(denv),
                       .quo(dvay_q));
   ccr_div u_div_shbx (.clock(clock), .en(en), .num(DIV_NUM_W'(shbx_ff)), .den(denp3_ff),
                       .quo(shbx_q));
   ccr_div u_div_shby (.clock(clock), .en(en), .num(DIV_NUM_W'(shby_ff)), .den(denp3_ff),
                       .quo(shby_q));
   ccr_div u_div_shax (.clock(clock), .en(en), .num(DIV_NUM_W'(shax_ff)), .den(denp3_ff),
                       .quo(shax_q));
   ccr_div u_div_shay (.clock(clock), .en(en), .num(DIV_NUM_W'(shay_ff)), .den(denp3_ff),
                       .quo(shay_q));

   assign cl     = ctx_ff[PIPE_DEPTH-1];
   assign vel_on = cl.active && cl.vneg;

   always_comb begin
      res_in.new_a_pos_x = cl.active
         ? sat_pos($signed({2'b00, cl.pl.a_pos_x}) - (POS_W+2)'(shax_q)) : cl.pl.a_pos_x;
      res_in.new_a_pos_y = cl.active
         ? sat_pos($signed({2'b00, cl.pl.a_pos_y}) - (POS_W+2)'(shay_q)) : cl.pl.a_pos_y;
      res_in.new_b_pos_x = cl.active
         ? sat_pos($signed({2'b00, cl.pl.b_pos_x}) + (POS_W+2)'(shbx_q)) : cl.pl.b_pos_x;
      res_in.new_b_pos_y = cl.active
         ? sat_pos($signed({2'b00, cl.pl.b_pos_y}) + (POS_W+2)'(shby_q)) : cl.pl.b_pos_y;
      res_in.new_a_vel_x = vel_on
         ? sat_vel((VEL_W+5)'(cl.pl.a_vel_x) + (VEL_W+5)'(dvax_q)) : cl.pl.a_vel_x;
      res_in.new_a_vel_y = vel_on
         ? sat_vel((VEL_W+5)'(cl.pl.a_vel_y) + (VEL_W+5)'(dvay_q)) : cl.pl.a_vel_y;
      res_in.new_b_vel_x = vel_on
         ? sat_vel((VEL_W+5)'(cl.pl.b_vel_x) - (VEL_W+5)'(dvbx_q)) : cl.pl.b_vel_x;
      res_in.new_b_vel_y = vel_on
         ? sat_vel((VEL_W+5)'(cl.pl.b_vel_y) - (VEL_W+5)'(dvby_q)) : cl.pl.b_vel_y;
      res_in.overlapping = cl.overlap;
      res_in.coincident  = cl.coinc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= '0;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (en) begin
            v_ff <= {v_ff[PIPE_DEPTH-1:1], acc};
         end
         if (!out_v_ff || take) begin
            if (skid_v_ff) begin
               out_v_ff  <= 1'b1;
               skid_v_ff <= 1'b0;
            end else begin
               out_v_ff <= push;
            end
         end else if (push) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || take) begin
         if (skid_v_ff) begin
            out_ff <= skid_ff;
         end else if (push) begin
            out_ff <= res_ff;
         end
      end else if (push) begin
         skid_ff <= res_ff;
      end
   end

endmodule

FILE: sv/ccr_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
`timescale 1ns / 1ps

module ccr_sqrt import ccr_pkg::*; (
   input  logic                clock,
   input  logic                en,
   input  logic [SQ_IN_W-1:0]  rad,
   output logic [SQ_OUT_W-1:0] root
);

   logic [SQ_IN_W-1:0] v_ff [1:SQ_STEPS-1];
   logic [SQ_IN_W-1:0] r_ff [1:SQ_STEPS];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      logic [SQ_IN_W-1:0] v_cur;
      logic [SQ_IN_W-1:0] r_cur;
      logic [SQ_IN_W-1:0] r_in;
      logic [SQ_IN_W:0]   bit_v;
      logic [SQ_IN_W:0]   trial;
      logic               fit;

      if (k == 0) begin : g_first
         assign v_cur = rad;
         assign r_cur = '0;
      end else begin : g_next
         assign v_cur = v_ff[k];
         assign r_cur = r_ff[k];
      end

      assign bit_v = (SQ_IN_W+1)'(1) << (2 * (SQ_STEPS - 1 - k));
      assign trial = {1'b0, r_cur} + bit_v;
      assign fit   = {1'b0, v_cur} >= trial;
      assign r_in  = fit ? (r_cur >> 1) + bit_v[SQ_IN_W-1:0] : r_cur >> 1;

      if (k < SQ_STEPS - 1) begin : g_rem
         logic [SQ_IN_W-1:0] v_in;
         assign v_in = fit ? v_cur - trial[SQ_IN_W-1:0] : v_cur;
         always_ff @(posedge clock) begin
            if (en) begin
               v_ff[k+1] <= v_in;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k+1] <= r_in;
         end
      end
   end

   assign root = r_ff[SQ_STEPS][SQ_OUT_W-1:0];

endmodule

FILE: sv/ccr_div.sv
// Pipelined signed divider with round-half-away-from-zero, one quotient bit per stage.
`timescale 1ns / 1ps

module ccr_div import ccr_pkg::*; (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0]        den,
   output logic signed [DIV_QW:0]      quo
);

   logic [DIV_NUM_W-1:0] rem_ff [0:DIV_QW-1];
   logic [DIV_DEN_W-1:0] den_ff [0:DIV_QW-1];
   logic [DIV_QW-1:0]    q_ff   [0:DIV_QW];
   logic                 neg_ff [0:DIV_QW];
   logic [DIV_NUM_W-1:0] mag_in;

   // Magnitude plus half the divisor in a single adder, using the carry-in for negation.
   assign mag_in = (num[DIV_NUM_W-1] ? ~$unsigned(num) : $unsigned(num))
                 + DIV_NUM_W'(den >> 1) + DIV_NUM_W'(num[DIV_NUM_W-1]);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= mag_in;
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         neg_ff[0] <= num[DIV_NUM_W-1];
      end
   end

   for (genvar i = 0; i < DIV_QW; i++) begin : g_bit
      logic [DIV_NUM_W-1:0] dsh;
      logic                 fit;
      logic [DIV_QW-1:0]    q_in;

      assign dsh  = DIV_NUM_W'(den_ff[i]) << (DIV_QW - 1 - i);
      assign fit  = rem_ff[i] >= dsh;
      assign q_in = fit ? q_ff[i] | (DIV_QW'(1) << (DIV_QW - 1 - i)) : q_ff[i];

      if (i < DIV_QW - 1) begin : g_carry
         logic [DIV_NUM_W-1:0] rem_in;
         assign rem_in = fit ? rem_ff[i] - dsh : rem_ff[i];
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i+1] <= rem_in;
               den_ff[i+1] <= den_ff[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[i+1]   <= q_in;
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   assign quo = neg_ff[DIV_QW] ? -$signed({1'b0, q_ff[DIV_QW]})
                               : $signed({1'b0, q_ff[DIV_QW]});

endmodule

FILE: sv/ccr_checker.sv
// Port-level assertions for the collision pipeline, bound to the top level.
`timescale 1ns / 1ps

module ccr_checker import ccr_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   logic [5:0] cnt_ff;
   logic [5:0] cnt_in;

   assign cnt_in = cnt_ff + 6'(req_valid && req_ready) - 6'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // A stalled response transaction stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Every response transaction belongs to an earlier request transaction.
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != '0)
      else $error("response without outstanding request");

   // The pipeline, output register and skid never hold more than their capacity.
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 6'(CAPACITY))
      else $error("more transactions in flight than storage");

   // Reset empties the output side.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind circle_pair_collision_resolve ccr_checker u_ccr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready)
);
